// File: hw/rtl/rarmt_pkg.sv
// ----------------------------------------------------------------------------
// rarmt_pkg
// Shared types, constants and arithmetic helpers for the range add / range
// max tree.
// ----------------------------------------------------------------------------
package rarmt_pkg;

  localparam int IDX_W      = 10;               // leaf index width
  localparam int LEVELS     = IDX_W;            // tree depth below the root
  localparam int NODE_W     = IDX_W + 1;        // node number width (1..2047)
  localparam int NODE_DEPTH = 1 << NODE_W;      // node store depth
  localparam int LVL_W      = 4;                // holds 0..LEVELS
  localparam int DATA_W     = 48;

  localparam logic signed [DATA_W-1:0] SENTINEL  = -(48'sh4000_0000_0000);
  localparam logic signed [DATA_W-1:0] POS_LIMIT = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [DATA_W-1:0] NEG_LIMIT = 48'sh8000_0000_0000;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_QUERY = 2'd1,
    MODE_SET   = 2'd2
  } mode_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_NODE,
    ST_EVAL,
    ST_CH_A,
    ST_CH_B,
    ST_CH_C,
    ST_ACT,
    ST_RETURN,
    ST_PULL_A,
    ST_PULL_B,
    ST_PULL_C,
    ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic clr_step;
    logic rd_node;
    logic eval;
    logic ch_a;
    logic ch_b;
    logic ch_c;
    logic ch_amt;
    logic act;
    logic go_child;
    logic go_sib;
    logic go_parent;
    logic pull_a;
    logic pull_b;
    logic pull_c;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic in_skip;
    logic in_query;
    logic is_query;
    logic is_add;
    logic leaf;
    logic p_nz;
    logic disjoint;
    logic covered;
    logic root;
    logic k_odd;
    logic out_free;
  } status_t;

  // 48-bit add that clamps at the signed limits
  function automatic data_t sat_add(data_t a, data_t b);
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) begin
      sat_add = s[DATA_W] ? NEG_LIMIT : POS_LIMIT;
    end else begin
      sat_add = s[DATA_W-1:0];
    end
  endfunction

endpackage

// File: hw/rtl/rarmt_ctrl.sv
// ----------------------------------------------------------------------------
// rarmt_ctrl
// Sequencer for the tree walk: clear sweep, per-node push, action, return
// and pull steps.
// ----------------------------------------------------------------------------
module rarmt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rarmt_pkg::status_t sts,
  output rarmt_pkg::cmd_t    cmd
);

  rarmt_pkg::state_t state_r, state_nxt;
  logic phase_r, phase_nxt;   // 1: child push carries the add amount

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rarmt_pkg::ST_CLEAR;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    unique case (state_r)
      rarmt_pkg::ST_CLEAR: begin
        if (sts.clr_last) state_nxt = rarmt_pkg::ST_IDLE;
      end
      rarmt_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (!sts.in_skip)     state_nxt = rarmt_pkg::ST_RD_NODE;
          else if (sts.in_query) state_nxt = rarmt_pkg::ST_DONE;
        end
      end
      rarmt_pkg::ST_RD_NODE: state_nxt = rarmt_pkg::ST_EVAL;
      rarmt_pkg::ST_EVAL: begin
        phase_nxt = 1'b0;
        if (!sts.leaf && sts.p_nz) state_nxt = rarmt_pkg::ST_CH_A;
        else                       state_nxt = rarmt_pkg::ST_ACT;
      end
      rarmt_pkg::ST_CH_A: state_nxt = rarmt_pkg::ST_CH_B;
      rarmt_pkg::ST_CH_B: state_nxt = rarmt_pkg::ST_CH_C;
      rarmt_pkg::ST_CH_C: begin
        state_nxt = phase_r ? rarmt_pkg::ST_RETURN : rarmt_pkg::ST_ACT;
      end
      rarmt_pkg::ST_ACT: begin
        if (sts.disjoint) begin
          state_nxt = rarmt_pkg::ST_RETURN;
        end else if (sts.covered) begin
          if (sts.is_add && !sts.leaf) begin
            state_nxt = rarmt_pkg::ST_CH_A;
            phase_nxt = 1'b1;
          end else begin
            state_nxt = rarmt_pkg::ST_RETURN;
          end
        end else begin
          state_nxt = rarmt_pkg::ST_RD_NODE;
        end
      end
      rarmt_pkg::ST_RETURN: begin
        if (sts.root)         state_nxt = rarmt_pkg::ST_DONE;
        else if (!sts.k_odd)  state_nxt = rarmt_pkg::ST_RD_NODE;
        else if (sts.is_query) state_nxt = rarmt_pkg::ST_RETURN;
        else                  state_nxt = rarmt_pkg::ST_PULL_A;
      end
      rarmt_pkg::ST_PULL_A: state_nxt = rarmt_pkg::ST_PULL_B;
      rarmt_pkg::ST_PULL_B: state_nxt = rarmt_pkg::ST_PULL_C;
      rarmt_pkg::ST_PULL_C: state_nxt = rarmt_pkg::ST_RETURN;
      rarmt_pkg::ST_DONE: begin
        if (!sts.is_query || sts.out_free) state_nxt = rarmt_pkg::ST_IDLE;
      end
      default: state_nxt = rarmt_pkg::ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      rarmt_pkg::ST_CLEAR:   cmd.clr_step = 1'b1;
      rarmt_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      rarmt_pkg::ST_RD_NODE: cmd.rd_node = 1'b1;
      rarmt_pkg::ST_EVAL:    cmd.eval = 1'b1;
      rarmt_pkg::ST_CH_A: begin
        cmd.ch_a   = 1'b1;
        cmd.ch_amt = phase_r;
      end
      rarmt_pkg::ST_CH_B: begin
        cmd.ch_b   = 1'b1;
        cmd.ch_amt = phase_r;
      end
      rarmt_pkg::ST_CH_C: begin
        cmd.ch_c   = 1'b1;
        cmd.ch_amt = phase_r;
      end
      rarmt_pkg::ST_ACT: begin
        cmd.act      = 1'b1;
        cmd.go_child = !sts.disjoint && !sts.covered;
      end
      rarmt_pkg::ST_RETURN: begin
        cmd.go_sib    = !sts.root && !sts.k_odd;
        cmd.go_parent = !sts.root && sts.k_odd;
      end
      rarmt_pkg::ST_PULL_A:  cmd.pull_a = 1'b1;
      rarmt_pkg::ST_PULL_B:  cmd.pull_b = 1'b1;
      rarmt_pkg::ST_PULL_C:  cmd.pull_c = 1'b1;
      rarmt_pkg::ST_DONE:    cmd.out_load = sts.is_query && sts.out_free;
      default: ;
    endcase
  end

endmodule

// File: hw/rtl/rarmt_dp.sv
// ----------------------------------------------------------------------------
// rarmt_dp
// Node stores, walk registers, saturating arithmetic and the result register.
// ----------------------------------------------------------------------------
module rarmt_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rarmt_pkg::cmd_t                     cmd,
  output rarmt_pkg::status_t                  sts,
  input  logic [1:0]                          in_mode,
  input  logic [rarmt_pkg::IDX_W-1:0]         in_range_low,
  input  logic [rarmt_pkg::IDX_W-1:0]         in_range_high,
  input  logic signed [rarmt_pkg::DATA_W-1:0] in_amount,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [rarmt_pkg::DATA_W-1:0] out_max_value,
  output logic                                out_empty_range
);

  localparam int NW = rarmt_pkg::NODE_W;
  localparam int IW = rarmt_pkg::IDX_W;

  // node stores
  rarmt_pkg::data_t max_mem  [rarmt_pkg::NODE_DEPTH];
  rarmt_pkg::data_t pend_mem [rarmt_pkg::NODE_DEPTH];
  rarmt_pkg::data_t max_rd_r, pend_rd_r;

  logic             max_we, pend_we, max_re, pend_re;
  logic [NW-1:0]    max_waddr, pend_waddr, max_raddr, pend_raddr;
  rarmt_pkg::data_t max_wdata, pend_wdata;

  // walk registers
  logic [NW-1:0]               clr_cnt_r;
  logic [NW-1:0]               k_r;
  logic [rarmt_pkg::LVL_W-1:0] d_r;
  rarmt_pkg::mode_t            mode_r;
  logic [IW-1:0]               l_r, r_r;
  rarmt_pkg::data_t            amt_r, p_r, m1_r, cmax0_r, best_r;
  logic                        found_r;
  logic                        out_valid_r;
  rarmt_pkg::data_t            out_max_r;
  logic                        out_empty_r;

  // node span
  logic [NW-1:0]               off, off_s, span_m;
  logic [rarmt_pkg::LVL_W-1:0] sh;
  logic [IW-1:0]               node_lo, node_hi;
  logic [NW-1:0]               ch0, ch1;
  rarmt_pkg::data_t            m1, ch_x, pull_max;

  assign sh      = rarmt_pkg::LVL_W'(rarmt_pkg::LEVELS) - d_r;
  assign off     = k_r ^ (NW'(1) << d_r);
  assign off_s   = off << sh;
  assign span_m  = (NW'(1) << sh) - NW'(1);
  assign node_lo = off_s[IW-1:0];
  assign node_hi = node_lo | span_m[IW-1:0];
  assign ch0     = {k_r[NW-2:0], 1'b0};
  assign ch1     = {k_r[NW-2:0], 1'b1};
  assign m1      = rarmt_pkg::sat_add(max_rd_r, pend_rd_r);
  assign ch_x    = rarmt_pkg::sat_add(pend_rd_r, cmd.ch_amt ? amt_r : p_r);
  assign pull_max = (cmax0_r > max_rd_r) ? cmax0_r : max_rd_r;

  always_comb begin
    sts.clr_last = (clr_cnt_r == {NW{1'b1}});
    sts.in_query = (in_mode == rarmt_pkg::MODE_QUERY);
    sts.in_skip  = !((in_mode == rarmt_pkg::MODE_SET) ||
                     (((in_mode == rarmt_pkg::MODE_ADD) ||
                       (in_mode == rarmt_pkg::MODE_QUERY)) &&
                      (in_range_low <= in_range_high)));
    sts.is_query = (mode_r == rarmt_pkg::MODE_QUERY);
    sts.is_add   = (mode_r == rarmt_pkg::MODE_ADD);
    sts.leaf     = (d_r == rarmt_pkg::LVL_W'(rarmt_pkg::LEVELS));
    sts.p_nz     = (pend_rd_r != '0);
    sts.disjoint = (node_lo > r_r) || (node_hi < l_r);
    sts.covered  = (l_r <= node_lo) && (node_hi <= r_r);
    sts.root     = (d_r == '0);
    sts.k_odd    = k_r[0];
    sts.out_free = !out_valid_r || !out_stall;
  end

  // store port control
  always_comb begin
    max_we = 1'b0; max_waddr = k_r; max_wdata = m1;
    pend_we = 1'b0; pend_waddr = k_r; pend_wdata = '0;
    max_re = 1'b0; max_raddr = k_r;
    pend_re = 1'b0; pend_raddr = k_r;
    if (cmd.clr_step) begin
      max_we = 1'b1; max_waddr = clr_cnt_r; max_wdata = rarmt_pkg::SENTINEL;
      pend_we = 1'b1; pend_waddr = clr_cnt_r;
    end
    if (cmd.rd_node) begin
      max_re = 1'b1; pend_re = 1'b1;
    end
    if (cmd.eval) begin
      max_we = 1'b1; pend_we = 1'b1;
    end
    if (cmd.ch_a) begin
      pend_re = 1'b1; pend_raddr = ch0;
    end
    if (cmd.ch_b) begin
      pend_we = 1'b1; pend_waddr = ch0; pend_wdata = ch_x;
      pend_re = 1'b1; pend_raddr = ch1;
    end
    if (cmd.ch_c) begin
      pend_we = 1'b1; pend_waddr = ch1; pend_wdata = ch_x;
    end
    if (cmd.act && sts.covered && !sts.disjoint) begin
      if (mode_r == rarmt_pkg::MODE_ADD) begin
        max_we = 1'b1; max_wdata = rarmt_pkg::sat_add(m1_r, amt_r);
      end else if (mode_r == rarmt_pkg::MODE_SET) begin
        max_we = 1'b1; max_wdata = amt_r;
      end
    end
    if (cmd.pull_a) begin
      max_re = 1'b1; max_raddr = ch0;
    end
    if (cmd.pull_b) begin
      max_re = 1'b1; max_raddr = ch1;
    end
    if (cmd.pull_c) begin
      max_we = 1'b1; max_wdata = pull_max;
    end
  end

  always_ff @(posedge clk) begin
    if (max_we) max_mem[max_waddr] <= max_wdata;
    if (max_re) max_rd_r <= max_mem[max_raddr];
  end

  always_ff @(posedge clk) begin
    if (pend_we) pend_mem[pend_waddr] <= pend_wdata;
    if (pend_re) pend_rd_r <= pend_mem[pend_raddr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      k_r         <= NW'(1);
      d_r         <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_step) clr_cnt_r <= clr_cnt_r + NW'(1);
      if (cmd.load) begin
        k_r     <= NW'(1);
        d_r     <= '0;
        found_r <= 1'b0;
      end
      if (cmd.go_child) begin
        k_r <= ch0;
        d_r <= d_r + rarmt_pkg::LVL_W'(1);
      end
      if (cmd.go_sib) k_r <= k_r + NW'(1);
      if (cmd.go_parent) begin
        k_r <= k_r >> 1;
        d_r <= d_r - rarmt_pkg::LVL_W'(1);
      end
      if (cmd.act && sts.covered && !sts.disjoint && sts.is_query) found_r <= 1'b1;
      if (cmd.out_load)    out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= rarmt_pkg::mode_t'(in_mode);
      l_r    <= in_range_low;
      r_r    <= (in_mode == rarmt_pkg::MODE_SET) ? in_range_low : in_range_high;
      amt_r  <= in_amount;
      best_r <= rarmt_pkg::SENTINEL;
    end
    if (cmd.eval) begin
      m1_r <= m1;
      p_r  <= pend_rd_r;
    end
    if (cmd.act && sts.covered && !sts.disjoint && sts.is_query) begin
      best_r <= (!found_r || (m1_r > best_r)) ? m1_r : best_r;
    end
    if (cmd.pull_b) cmax0_r <= max_rd_r;
    if (cmd.out_load) begin
      out_max_r   <= found_r ? best_r : rarmt_pkg::SENTINEL;
      out_empty_r <= !found_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_max_value   = out_max_r;
  assign out_empty_range = out_empty_r;

endmodule

// File: hw/rtl/range_add_range_max_tree_unit.sv
// ----------------------------------------------------------------------------
// range_add_range_max_tree_unit
// Lazy segment tree over 1024 signed 48-bit entries: range add, range max
// query and point set, with saturating sums.
// ----------------------------------------------------------------------------
//
//  channel | ports                                        | direction
//  --------+----------------------------------------------+----------
//  input   | in_valid, in_stall, in_mode, in_range_low,   | in
//          | in_range_high, in_amount                     |
//  result  | out_valid, out_stall, out_max_value,         | out
//          | out_empty_range (query transactions only)    |
//
//  Reset clears the node stores in a sweep over every node address; in_stall
//  is high until it finishes.
//  One transaction at a time. Each visited node is read, its pending value
//  folded in, acted on and returned from; a pending add is handed to its
//  children before the act, a covered add is handed down after it, and on
//  the way up the max is pulled from the children (add and set only). The
//  node stores have one read and one write port each; a transaction visits
//  about 40 nodes worst case for a wide range.
//  A query result sits in the output register; the next transaction is
//  taken while it waits, and is held at its end until out_stall drops.
//
module range_add_range_max_tree_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_mode,
  input  logic [rarmt_pkg::IDX_W-1:0]         in_range_low,
  input  logic [rarmt_pkg::IDX_W-1:0]         in_range_high,
  input  logic signed [rarmt_pkg::DATA_W-1:0] in_amount,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [rarmt_pkg::DATA_W-1:0] out_max_value,
  output logic                                out_empty_range
);

  rarmt_pkg::cmd_t    cmd;
  rarmt_pkg::status_t sts;

  // walk sequencer
  rarmt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // node stores and arithmetic
  rarmt_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_mode         (in_mode),
    .in_range_low    (in_range_low),
    .in_range_high   (in_range_high),
    .in_amount       (in_amount),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_max_value   (out_max_value),
    .out_empty_range (out_empty_range)
  );

endmodule
